[sv/sdsu_pkg.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar package
// Shared types, fixed-point constants and saturating helpers for the
// critically damped follower.
// ----------------------------------------------------------------------------
package sdsu_pkg;

   // Fixed-point format of every value (Q16.16 at the ports).
   localparam int FRAC_BITS = 16;

   typedef logic signed [63:0] wide_type;

   // Internal values saturate at plus or minus two to the 62nd.
   localparam wide_type CAP = 64'sh4000_0000_0000_0000;
   localparam wide_type ONE = 64'sd1 <<< FRAC_BITS;

   // Floor of the smoothing time, about 0.0001.
   localparam longint MIN_ST_L = ((longint'(1) <<< FRAC_BITS) + 9999) / 10000;
   localparam wide_type MIN_ST = wide_type'(MIN_ST_L);

   // Decay polynomial coefficients, rounded to nearest.
   localparam longint K48_L  = (48 * (longint'(1) <<< FRAC_BITS) + 50) / 100;
   localparam longint K235_L = (235 * (longint'(1) <<< FRAC_BITS) + 500) / 1000;
   localparam wide_type K48  = wide_type'(K48_L);
   localparam wide_type K235 = wide_type'(K235_L);

   // Upper bound of omega times delta time (4096.0).
   localparam wide_type XMAX = 64'sd1 <<< (FRAC_BITS + 12);

   // Dividends of the two divisions.
   localparam logic [63:0] OMEGA_NUM = 64'd2 << (2 * FRAC_BITS);
   localparam logic [63:0] DECAY_NUM = 64'd1 << (2 * FRAC_BITS);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_TIME = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SPEED   = 8'd1;

   // Multiplications of one step, in the order they are issued.
   typedef enum logic [3:0] {
      MUL_X,
      MUL_X2,
      MUL_X3,
      MUL_T48,
      MUL_T235,
      MUL_LIM,
      MUL_A,
      MUL_TEMP,
      MUL_B,
      MUL_NV,
      MUL_C
   } mul_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       div_start;
      logic       div_decay;
      logic       mul_start;
      mul_op_type mul_op;
      logic       den_en;
      logic       off_en;
      logic       finish;
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic mul_done;
   } ctl_status_type;

   // Clamp a signed value into a range.
   function automatic wide_type sclamp(wide_type v, wide_type lo, wide_type hi);
      wide_type r;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Saturating add at plus or minus CAP.
   function automatic wide_type sat_add(wide_type a, wide_type b);
      logic signed [64:0] s;
      logic signed [64:0] cap_x;
      wide_type r;
      s     = {a[63], a} + {b[63], b};
      cap_x = {1'b0, CAP};
      if (s > cap_x) begin
         r = CAP;
      end else if (s < -cap_x) begin
         r = -CAP;
      end else begin
         r = s[63:0];
      end
      return r;
   endfunction

endpackage

[sv/sdsu_mul.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar multiplier
// Signed fixed-point multiply over four 32 by 32 partial products, one per
// cycle; the magnitude is truncated by FRAC_BITS and saturated at CAP.
// ----------------------------------------------------------------------------
module sdsu_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sdsu_pkg::wide_type op_a,
   input  sdsu_pkg::wide_type op_b,
   output logic              done,
   output sdsu_pkg::wide_type result
);
   import sdsu_pkg::*;

   logic [63:0]  am_ff;
   logic [63:0]  bm_ff;
   logic         neg_ff;
   logic [127:0] acc_ff;
   logic [1:0]   cnt_ff;
   logic         busy_ff;
   logic         done_ff;

   logic [31:0]  a_part;
   logic [31:0]  b_part;
   logic [63:0]  pp;
   logic [1:0]   sh;
   logic [127:0] ppx;
   logic [111:0] q;
   logic [63:0]  mag;

   // Pick the partial product of this cycle and align it.
   always_comb begin
      a_part = cnt_ff[0] ? am_ff[63:32] : am_ff[31:0];
      b_part = cnt_ff[1] ? bm_ff[63:32] : bm_ff[31:0];
      pp     = a_part * b_part;
      sh     = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
      ppx    = {64'd0, pp} << {sh, 5'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 2'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand magnitudes and accumulator.
   always_ff @(posedge clock) begin
      if (start) begin
         am_ff  <= op_a[63] ? 64'(-op_a) : 64'(op_a);
         bm_ff  <= op_b[63] ? 64'(-op_b) : 64'(op_b);
         neg_ff <= op_a[63] ^ op_b[63];
         acc_ff <= 128'd0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + ppx;
      end
   end

   // Truncate, saturate and restore the sign.
   always_comb begin
      q   = acc_ff[127:FRAC_BITS];
      mag = (q > 112'(CAP)) ? 64'(CAP) : q[63:0];
   end

   assign result = neg_ff ? -wide_type'(mag) : wide_type'(mag);
   assign done   = done_ff;

endmodule

[sv/sdsu_div.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar divider
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sdsu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [64:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] d_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [64:0] rem_sh;
   logic        ge;
   logic [64:0] rem_in;
   logic [63:0] quo_in;

   // One restoring step.
   always_comb begin
      rem_sh = {rem_ff[63:0], quo_ff[63]};
      ge     = rem_sh >= {1'b0, d_ff};
      rem_in = ge ? rem_sh - {1'b0, d_ff} : rem_sh;
      quo_in = {quo_ff[62:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= 65'd0;
         quo_ff <= dividend;
         d_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/sdsu_datapath.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar datapath
// Step operands, configuration registers, velocity state, the shared
// multiplier and divider, and the result registers.
// ----------------------------------------------------------------------------
module sdsu_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sdsu_pkg::ctl_cmd_type                cmd,
   output sdsu_pkg::ctl_status_type             status,
   input  logic signed [31:0]                   req_current_pos,
   input  logic signed [31:0]                   req_target_pos,
   input  logic [31:0]                          req_delta_time,
   input  logic                                 csr_wen,
   input  logic [sdsu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata,
   output logic signed [31:0]                   rsp_new_pos,
   output logic signed [31:0]                   rsp_new_velocity
);
   import sdsu_pkg::*;

   localparam wide_type I32_MIN = -(64'sd1 <<< 31);
   localparam wide_type I32_MAX = (64'sd1 <<< 31) - 64'sd1;

   logic [31:0] smooth_time_ff;
   logic [31:0] max_speed_ff;
   wide_type    velocity_ff;

   wide_type cur_ff, tgt_ff, dt_ff, st_ff;
   wide_type omega_ff, x_ff, x2_ff, x3_ff, t48_ff, t235_ff, den_ff, decay_ff;
   wide_type lim_ff, off_ff, tgt2_ff, s1_ff, temp_ff, s2_ff, nv_ff, np_ff;
   logic signed [31:0] out_pos_ff;
   logic signed [31:0] out_vel_ff;

   wide_type    mul_a, mul_b, mul_res;
   logic        mul_done;
   logic        div_done;
   logic [63:0] div_num, div_den, div_quo;
   wide_type    diff, off_c, np_f, nv_f;
   logic        snap;

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_op)
         MUL_X:    begin mul_a = omega_ff; mul_b = dt_ff; end
         MUL_X2:   begin mul_a = x_ff; mul_b = x_ff; end
         MUL_X3:   begin mul_a = x2_ff; mul_b = x_ff; end
         MUL_T48:  begin mul_a = K48; mul_b = x2_ff; end
         MUL_T235: begin mul_a = K235; mul_b = x3_ff; end
         MUL_LIM:  begin mul_a = {32'd0, max_speed_ff}; mul_b = st_ff; end
         MUL_A:    begin mul_a = omega_ff; mul_b = off_ff; end
         MUL_TEMP: begin mul_a = s1_ff; mul_b = dt_ff; end
         MUL_B:    begin mul_a = omega_ff; mul_b = temp_ff; end
         MUL_NV:   begin mul_a = s2_ff; mul_b = decay_ff; end
         MUL_C:    begin mul_a = sat_add(off_ff, temp_ff); mul_b = decay_ff; end
         default:  begin mul_a = '0; mul_b = '0; end
      endcase
   end

   sdsu_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // Divider operands: omega first, then the decay factor.
   always_comb begin
      if (cmd.div_decay) begin
         div_num = DECAY_NUM + {1'b0, den_ff[63:1]};
         div_den = den_ff;
      end else begin
         div_num = OMEGA_NUM;
         div_den = st_ff;
      end
   end

   sdsu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign status.div_done = div_done;
   assign status.mul_done = mul_done;

   // Configuration registers and velocity state.
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_time_ff <= 32'd65536;
         max_speed_ff   <= 32'hFFFF_FFFF;
         velocity_ff    <= '0;
      end else begin
         if (csr_wen && csr_index == CSR_SMOOTH_TIME) begin
            smooth_time_ff <= csr_wdata;
         end
         if (csr_wen && csr_index == CSR_MAX_SPEED) begin
            max_speed_ff <= csr_wdata;
         end
         if (cmd.finish) begin
            velocity_ff <= sclamp(nv_f, I32_MIN, I32_MAX);
         end
      end
   end

   // Offset clamp and overshoot test; the final saturation is applied where the results are registered.
   always_comb begin
      off_c = sclamp(cur_ff - tgt_ff, -lim_ff, lim_ff);
      diff  = tgt_ff - cur_ff;
      snap  = (diff > 64'sd0) == (np_ff > tgt_ff);
      np_f  = snap ? tgt_ff : np_ff;
      nv_f  = snap ? 64'sd0 : nv_ff;
   end

   // Working registers of one step.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff <= wide_type'(req_current_pos);
         tgt_ff <= wide_type'(req_target_pos);
         dt_ff  <= {32'd0, req_delta_time};
         st_ff  <= ({32'd0, smooth_time_ff} < MIN_ST) ? MIN_ST : {32'd0, smooth_time_ff};
      end
      if (div_done) begin
         if (cmd.div_decay) begin
            decay_ff <= wide_type'(div_quo);
         end else begin
            omega_ff <= wide_type'(div_quo);
         end
      end
      if (cmd.den_en) begin
         den_ff <= ONE + x_ff + t48_ff + t235_ff;
      end
      if (cmd.off_en) begin
         off_ff  <= off_c;
         tgt2_ff <= cur_ff - off_c;
      end
      if (mul_done) begin
         unique case (cmd.mul_op)
            MUL_X:    x_ff    <= (mul_res > XMAX) ? XMAX : mul_res;
            MUL_X2:   x2_ff   <= mul_res;
            MUL_X3:   x3_ff   <= mul_res;
            MUL_T48:  t48_ff  <= mul_res;
            MUL_T235: t235_ff <= mul_res;
            MUL_LIM:  lim_ff  <= mul_res;
            MUL_A:    s1_ff   <= sat_add(velocity_ff, mul_res);
            MUL_TEMP: temp_ff <= mul_res;
            MUL_B:    s2_ff   <= sat_add(velocity_ff, -mul_res);
            MUL_NV:   nv_ff   <= mul_res;
            MUL_C:    np_ff   <= sat_add(tgt2_ff, mul_res);
            default:  ;
         endcase
      end
      if (cmd.finish) begin
         out_pos_ff <= 32'(sclamp(np_f, I32_MIN, I32_MAX));
         out_vel_ff <= 32'(sclamp(nv_f, I32_MIN, I32_MAX));
      end
   end

   assign rsp_new_pos      = out_pos_ff;
   assign rsp_new_velocity = out_vel_ff;

endmodule

[sv/sdsu_ctrl.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar controller
// Sequences the two divisions and eleven multiplications of one step and
// owns the request and result handshakes.
// ----------------------------------------------------------------------------
module sdsu_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  sdsu_pkg::ctl_status_type status,
   output sdsu_pkg::ctl_cmd_type    cmd
);
   import sdsu_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_OM,
      ST_WAIT_OM,
      ST_MUL,
      ST_WAIT_MUL,
      ST_DEN,
      ST_DIV_DC,
      ST_WAIT_DC,
      ST_OFFSET,
      ST_FINISH
   } state_type;

   state_type  state_ff;
   mul_op_type op_ff;
   logic       rsp_valid_ff;
   logic       accept;
   logic       out_free;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // State, operation counter and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= MUL_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_DIV_OM;
               end
            end
            ST_DIV_OM:  state_ff <= ST_WAIT_OM;
            ST_WAIT_OM: begin
               if (status.div_done) begin
                  op_ff    <= MUL_X;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL:     state_ff <= ST_WAIT_MUL;
            ST_WAIT_MUL: begin
               if (status.mul_done) begin
                  priority case (op_ff)
                     MUL_T235: state_ff <= ST_DEN;
                     MUL_LIM:  state_ff <= ST_OFFSET;
                     MUL_C:    state_ff <= ST_FINISH;
                     default: begin
                        op_ff    <= mul_op_type'(op_ff + 4'd1);
                        state_ff <= ST_MUL;
                     end
                  endcase
               end
            end
            ST_DEN:     state_ff <= ST_DIV_DC;
            ST_DIV_DC:  state_ff <= ST_WAIT_DC;
            ST_WAIT_DC: begin
               if (status.div_done) begin
                  op_ff    <= MUL_LIM;
                  state_ff <= ST_MUL;
               end
            end
            ST_OFFSET: begin
               op_ff    <= MUL_A;
               state_ff <= ST_MUL;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Commands decoded from the state.
   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.div_start = (state_ff == ST_DIV_OM) || (state_ff == ST_DIV_DC);
      cmd.div_decay = (state_ff == ST_DIV_DC) || (state_ff == ST_WAIT_DC);
      cmd.mul_start = (state_ff == ST_MUL);
      cmd.mul_op    = op_ff;
      cmd.den_en    = (state_ff == ST_DEN);
      cmd.off_en    = (state_ff == ST_OFFSET);
      cmd.finish    = (state_ff == ST_FINISH) && out_free;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/smooth_damp_scalar_unit.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar unit
// Critically damped follower: one position, target and time step in, one
// new position and velocity out, with the velocity kept between beats.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries current position, target and delta time (Q16.16).
// The rsp_ channel returns the new position and velocity, one beat per request.
// The csr_ channel writes smooth_time (index 0) and max_speed (index 1); it is
// always ready and should only be written while no request is in flight.
// One request is worked on at a time. Each step runs the bit-serial divider
// twice (omega and the decay factor) and makes eleven multiplications on the
// shared four-phase 32 by 32 multiplier.
// Reset clears the velocity to zero, sets smooth_time to 1.0 and max_speed
// to its maximum, and empties the result register.
// A finished result waits in the output register while the receiver stalls;
// a new request may be taken meanwhile, and it holds at its last step until
// the register is free.
// ----------------------------------------------------------------------------
module smooth_damp_scalar_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_current_pos,
   input  logic signed [31:0]                req_target_pos,
   input  logic [31:0]                       req_delta_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_new_pos,
   output logic signed [31:0]                rsp_new_velocity,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdsu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_wdata
);
   import sdsu_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   sdsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdsu_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_current_pos  (req_current_pos),
      .req_target_pos   (req_target_pos),
      .req_delta_time   (req_delta_time),
      .csr_wen          (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_new_pos      (rsp_new_pos),
      .rsp_new_velocity (rsp_new_velocity)
   );

endmodule

[sv/sdsu_checker.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar checker
// Port-level assertions on the unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module sdsu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [31:0]                rsp_new_pos,
   input logic signed [31:0]                rsp_new_velocity
);

   // A stalled result beat keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_pos)
         && $stable(rsp_new_velocity))
      else $error("result beat changed while stalled");

   // Reset empties the result register.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // One request at a time: the unit is busy after taking a beat.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a step was in progress");

   // A result never appears in the cycle after a request is taken.
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind smooth_damp_scalar_unit sdsu_checker u_sdsu_checker (.*);

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Smooth damp scalar unit testbench
// Drives position, target and time-step beats through the follower, predicts
// every result with a fixed-point model of the damped spring kept in a small
// scoreboard class, and checks each result beat field by field. Both sides
// idle at random, and the configuration is changed between drained phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sdsu_pkg::*;

   typedef logic signed [63:0] sval_type;
   typedef logic [63:0]        uval_type;

   // Predicted result of one step.
   typedef struct {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
   } damp_result_type;

   // Scoreboard: follower model state plus the queue of predicted results.
   class damp_scoreboard;
      uval_type        smooth_t;
      uval_type        speed_max;
      sval_type        vel_state;
      damp_result_type pending[$];
      int              errors;

      function new();
         smooth_t  = 64'd65536;
         speed_max = 64'hFFFF_FFFF;
         vel_state = 0;
         errors    = 0;
      endfunction

      // Unsigned product shifted down by the fraction bits, saturated.
      function uval_type mul_shift(uval_type a, uval_type b);
         logic [127:0] p;
         uval_type r;
         p = {64'd0, a} * {64'd0, b};
         if ((p >> (64 + FRAC_BITS)) != 0) return uval_type'(CAP);
         r = p[63+FRAC_BITS:FRAC_BITS];
         return (r > uval_type'(CAP)) ? uval_type'(CAP) : r;
      endfunction

      function uval_type magnitude(sval_type a);
         return (a < 0) ? uval_type'(-a) : uval_type'(a);
      endfunction

      // Signed product, magnitude truncated toward zero.
      function sval_type fix_mul(sval_type a, sval_type b);
         uval_type m;
         m = mul_shift(magnitude(a), magnitude(b));
         return ((a < 0) != (b < 0)) ? -sval_type'(m) : sval_type'(m);
      endfunction

      function sval_type limit(sval_type v, sval_type lo, sval_type hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      // Sum saturated at plus or minus the internal cap.
      function sval_type sat_sum(sval_type a, sval_type b);
         logic signed [64:0] s;
         logic signed [64:0] cap_x;
         s     = {a[63], a} + {b[63], b};
         cap_x = {1'b0, CAP};
         if (s > cap_x) return CAP;
         if (s < -cap_x) return -CAP;
         return s[63:0];
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
         if (idx == CSR_SMOOTH_TIME) smooth_t = {32'd0, data};
         else if (idx == CSR_MAX_SPEED) speed_max = {32'd0, data};
      endfunction

      // Predict the result of an accepted request beat.
      function void note_request(logic signed [31:0] cur_in, logic signed [31:0] tgt_in,
                                 logic [31:0] dt_in);
         sval_type cur, tgt, dt, omega, decay, lim, off, tgt2, temp, nv, np;
         uval_type st, x, x2, x3, den;
         damp_result_type res;
         cur = cur_in;
         tgt = tgt_in;
         dt  = {32'd0, dt_in};
         st  = (smooth_t < uval_type'(MIN_ST)) ? uval_type'(MIN_ST) : smooth_t;
         omega = sval_type'((64'd2 << (2 * FRAC_BITS)) / st);
         // Decay factor from the cubic approximation of the exponential.
         x = mul_shift(uval_type'(omega), uval_type'(dt));
         if (x > uval_type'(XMAX)) x = uval_type'(XMAX);
         x2 = mul_shift(x, x);
         x3 = mul_shift(x2, x);
         den = uval_type'(ONE) + x + mul_shift(uval_type'(K48), x2)
               + mul_shift(uval_type'(K235), x3);
         decay = sval_type'(((64'd1 << (2 * FRAC_BITS)) + den / 2) / den);
         // Offset clamped to the reachable distance.
         lim  = sval_type'(mul_shift(speed_max, st));
         off  = limit(cur - tgt, -lim, lim);
         tgt2 = cur - off;
         temp = fix_mul(sat_sum(vel_state, fix_mul(omega, off)), dt);
         nv   = fix_mul(sat_sum(vel_state, -fix_mul(omega, temp)), decay);
         np   = sat_sum(tgt2, fix_mul(sat_sum(off, temp), decay));
         // Overshoot past the target snaps to it and stops.
         if ((tgt - cur > 0) == (np > tgt)) begin
            np = tgt;
            nv = 0;
         end
         np = limit(np, -64'sd2147483648, 64'sd2147483647);
         nv = limit(nv, -64'sd2147483648, 64'sd2147483647);
         vel_state = nv;
         res.pos = np[31:0];
         res.vel = nv[31:0];
         pending.push_back(res);
      endfunction

      // Compare a result beat with the oldest prediction.
      function void check_result(logic signed [31:0] pos, logic signed [31:0] vel);
         damp_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat pos=%0d vel=%0d", $time, pos, vel);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (pos !== exp_r.pos) begin
            $display("%0t: new_pos expected %0d actual %0d", $time, exp_r.pos, pos);
            errors++;
         end
         if (vel !== exp_r.vel) begin
            $display("%0t: new_velocity expected %0d actual %0d", $time, exp_r.vel, vel);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_current_pos = '0;
   logic signed [31:0] req_target_pos = '0;
   logic [31:0] req_delta_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_new_pos;
   logic signed [31:0] rsp_new_velocity;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   damp_scoreboard sb = new();
   bit quiet = 0;

   smooth_damp_scalar_unit uut (.*);

   always #1 clock = ~clock;

   // Give up long after the slowest correct run would have finished.
   initial begin
      #4_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 14);
   endfunction

   // Send one request beat after a random gap.
   task automatic send_step(logic [31:0] cur, logic [31:0] tgt, logic [31:0] dt);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_current_pos <= cur;
      req_target_pos  <= tgt;
      req_delta_time  <= dt;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cur, tgt, dt);
   endtask

   // Wait until every predicted result beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic set_config(logic [31:0] st, logic [31:0] ms);
      drain();
      write_csr(CSR_SMOOTH_TIME, st);
      write_csr(CSR_MAX_SPEED, ms);
   endtask

   // Random position: mostly moderate, sometimes anywhere in range.
   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 3))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 65536)
                                        : 32'h8000_0000 + $urandom_range(0, 65536);
         default: return $urandom_range(0, 32'h00A0_0000) - 32'h0050_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_dt();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 16);
         default: return $urandom_range(0, 32'h0002_0000);
      endcase
   endfunction

   // Result side: random stall before each beat.
   initial begin
      int w;
      forever begin
         w = idle_draw();
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_new_pos, rsp_new_velocity);
      end
   end

   // Main sequence.
   initial begin
      logic [31:0] c, t;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at reset settings: extremes and the snap cases.
      send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1000);
      send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1000);
      send_step(32'h0001_0000, 32'h0001_0000, 32'h0000_1000);
      send_step(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
      send_step(32'h0000_0000, 32'h0010_0000, 32'h0000_0000);
      send_step(32'h0000_0000, 32'h0010_0000, 32'hFFFF_FFFF);
      send_step(32'h0010_0000, 32'h0000_0000, 32'h0000_4000);
      send_step(32'h0010_0000, 32'h0000_0000, 32'h0000_4000);
      send_step(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000);
      // Smoothing time below its floor, and the largest speed.
      set_config(32'h0000_0000, 32'hFFFF_FFFF);
      send_step(32'h0000_0000, 32'h0100_0000, 32'h0000_0001);
      send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0010);
      // Largest smoothing time with zero speed, then a tiny speed.
      set_config(32'hFFFF_FFFF, 32'h0000_0000);
      send_step(32'h0100_0000, 32'h0000_0000, 32'h0001_0000);
      send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      set_config(32'hFFFF_FFFF, 32'h0000_0001);
      send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0000);
      send_step(32'h0000_0000, 32'h0000_0001, 32'h0000_8000);
      set_config(32'h0000_0007, 32'h0001_0000);
      send_step(32'h0050_0000, 32'hFFB0_0000, 32'h0000_0100);
      send_step(32'h0050_0000, 32'hFFB0_0000, 32'h0000_0100);

      // Random phases, each under its own configuration.
      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: set_config($urandom_range(32'h0000_4000, 32'h0004_0000), 32'hFFFF_FFFF);
            1: set_config($urandom_range(0, 32'h0000_0100), $urandom());
            2: set_config($urandom(), $urandom_range(0, 32'h0010_0000));
            default: set_config($urandom_range(32'h0000_1000, 32'h0002_0000),
                                $urandom_range(32'h0000_1000, 32'h0100_0000));
         endcase
         quiet = (ph == 5 || ph == 11);
         for (int i = 0; i < 40; i++) begin
            c = rand_pos();
            t = ($urandom_range(0, 3) == 0) ? c + $urandom_range(0, 64) - 32 : rand_pos();
            send_step(c, t, rand_dt());
         end
         quiet = 0;
      end

      // Let everything drain, then allow for the block's latency.
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
